// ===== src/dca_pkg.sv =====
// ----------------------------------------------------------------------------
// dca_pkg
// Shared sizes, codes and types of the DLCI context allocator.
// ----------------------------------------------------------------------------
package dca_pkg;

    // Pool and map sizes
    localparam int NUM_CONTEXTS = 32;
    localparam int DLCI_SPACE   = 1024;
    localparam int DLCI_MAX     = 1023;

    // Field widths
    localparam int DLCI_W = 16;
    localparam int CTX_W  = 7;
    localparam int MAP_AW = (DLCI_SPACE > 1) ? $clog2(DLCI_SPACE) : 1;
    localparam int CNT_W  = $clog2(NUM_CONTEXTS + 1);

    // Result codes
    typedef enum logic [1:0] {
        ST_EXISTING = 2'd0,
        ST_NEW      = 2'd1,
        ST_FULL     = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    // One map entry: valid flag over the context index
    typedef struct packed {
        logic             valid;
        logic [CTX_W-1:0] idx;
    } t_map_entry;

    // Map write request
    typedef struct packed {
        logic              en;
        logic [MAP_AW-1:0] addr;
        t_map_entry        data;
    } t_map_wr;

    // Context pool status
    typedef struct packed {
        logic             full;
        logic [CTX_W-1:0] free_idx;
    } t_pool;

endpackage

// ===== src/dca_if.sv =====
// ----------------------------------------------------------------------------
// dca_req_if / dca_rsp_if
// Valid/ready channels for DLCI requests and allocation results.
// ----------------------------------------------------------------------------
interface dca_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] dlci;

    modport source (output valid, output dlci, input ready);
    modport sink   (input valid, input dlci, output ready);
endinterface

interface dca_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [6:0] context_index;

    modport source (output valid, output status, output context_index, input ready);
    modport sink   (input valid, input status, input context_index, output ready);
endinterface

// ===== src/dca_map_ram.sv =====
// ----------------------------------------------------------------------------
// dca_map_ram
// DLCI map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dca_map_ram
    import dca_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [MAP_AW-1:0] i_rd_addr,
    output t_map_entry        o_rd_data,
    input  t_map_wr           i_wr
);

    t_map_entry r_mem [DLCI_SPACE];
    t_map_entry r_rd_data;

    // Write the entry; the read data is registered
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/dca_ctx_pool.sv =====
// ----------------------------------------------------------------------------
// dca_ctx_pool
// Context busy tracking. Contexts are claimed lowest first and freed only
// by reset, so the busy set is always a prefix and a fill count holds it.
// ----------------------------------------------------------------------------
module dca_ctx_pool
    import dca_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_claim,
    output t_pool o_pool
);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             full;

    assign full = (r_cnt == CNT_W'(NUM_CONTEXTS));

    // Advance the fill count on each claim while the pool is not full
    always_comb begin
        n_cnt = r_cnt;
        if (i_claim && !full) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_pool.full     = full;
    assign o_pool.free_idx = CTX_W'(r_cnt);

endmodule

// ===== src/dlci_context_allocator_core.sv =====
// ----------------------------------------------------------------------------
// dlci_context_allocator_core
// Maps each requested DLCI to a context, claiming the lowest free one.
//
// Usage: i_req carries one DLCI per word; o_rsp returns one word per request
// with a status (existing, new, pool full, out of range) and the context.
// A request is taken on the edge where valid and ready are both high. The
// map is read on that edge, the decision and write-back happen in the next
// cycle, and the result enters the output register at the end of it.
// o_rsp.valid rises at the end of the lookup cycle, as the result word
// enters the output register. One request is in flight at a time: the next
// is taken only once the lookup is over and the state is back to idle.
// After reset the map is cleared one entry per cycle: i_req.ready stays low
// until the last entry is cleared. A stalled result holds in the output
// register; the next request is taken as soon as the register is free or
// drains in the same cycle.
// ----------------------------------------------------------------------------
module dlci_context_allocator_core
    import dca_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    dca_req_if.sink   i_req,
    dca_rsp_if.source o_rsp
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [MAP_AW-1:0] r_clr_addr;
    logic [MAP_AW-1:0] r_addr;
    logic              r_in_range;
    logic              r_out_valid;
    t_status           r_status;
    logic [CTX_W-1:0]  r_ctx;
    t_status           n_status;
    logic [CTX_W-1:0]  n_ctx;

    logic       accept;
    logic       in_range;
    logic       hit;
    logic       claim;
    t_map_entry rd_data;
    t_map_wr    look_wr;
    t_map_wr    map_wr;
    t_pool      pool;

    // Accept when idle and the output register is free by the next edge
    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;
    assign in_range    = (i_req.dlci <= DLCI_W'(DLCI_MAX)) &&
                         (i_req.dlci <  DLCI_W'(DLCI_SPACE));

    dca_map_ram u_map (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (i_req.dlci[MAP_AW-1:0]),
        .o_rd_data (rd_data),
        .i_wr      (map_wr)
    );

    dca_ctx_pool u_pool (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_claim (claim),
        .o_pool  (pool)
    );

    // Decide on the entry read back: out of range, hit, claim, or report full and drop a stale entry
    assign hit = rd_data.valid &&
                 ({1'b0, rd_data.idx} < (CTX_W + 1)'(NUM_CONTEXTS));

    always_comb begin
        n_status     = ST_RANGE;
        n_ctx        = '0;
        claim        = 1'b0;
        look_wr.en   = 1'b0;
        look_wr.addr = r_addr;
        look_wr.data = '0;
        if (r_state == S_LOOK) begin
            priority if (!r_in_range) begin
                n_status = ST_RANGE;
            end else if (hit) begin
                n_status = ST_EXISTING;
                n_ctx    = rd_data.idx;
            end else if (!pool.full) begin
                n_status           = ST_NEW;
                n_ctx              = pool.free_idx;
                claim              = 1'b1;
                look_wr.en         = 1'b1;
                look_wr.data.valid = 1'b1;
                look_wr.data.idx   = pool.free_idx;
            end else begin
                n_status   = ST_FULL;
                look_wr.en = rd_data.valid;
            end
        end
    end

    // Clearing pass owns the map port until it finishes
    always_comb begin
        if (r_state == S_CLEAR) begin
            map_wr.en   = 1'b1;
            map_wr.addr = r_clr_addr;
            map_wr.data = '0;
        end else begin
            map_wr = look_wr;
        end
    end

    // Sequence clear, idle and lookup
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == MAP_AW'(DLCI_SPACE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + MAP_AW'(1);
            end
            if (r_state == S_LOOK) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the request and the result word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr     <= i_req.dlci[MAP_AW-1:0];
            r_in_range <= in_range;
        end
        if (r_state == S_LOOK) begin
            r_status <= n_status;
            r_ctx    <= n_ctx;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.context_index = r_ctx;

    // No request is taken while the map is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_req.ready)
        else $error("request accepted during map clear");

    // Every accepted request shows a result after the lookup state and the output register
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> ##1 o_rsp.valid)
        else $error("result missing two cycles after accept");

    // Failed requests carry context zero
    a_fail_ctx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == ST_FULL || o_rsp.status == ST_RANGE))
        |-> (o_rsp.context_index == '0))
        else $error("nonzero context on a failed request");

    // A claim never happens on a full pool
    a_claim_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        claim |-> !pool.full)
        else $error("context claimed from a full pool");

endmodule
